// File: design/bsr_pkg.sv
`timescale 1ns / 1ps

package bsr_pkg;

    // fixed field widths
    localparam int VALUE_W = 32;
    localparam int ROOT_W  = 33;
    localparam int STEPS_W = 6;
    localparam int RES_W   = 40;   // root, steps_taken, converged; whole bytes
    localparam int PADDR_W = 3;
    localparam int UPC_W   = 4;

    localparam int MAX_STEPS_DEF = 48;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [31:0] TOL_RESET = 32'd6554;

    // register index carried in paddr[2]
    localparam logic REG_TOL = 1'b0;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [1:0] {
        MUL_HI,
        MUL_X,
        MUL_LO
    } mul_sel_t;

    typedef enum logic [1:0] {
        X_KEEP,
        X_INIT,
        X_STEP
    } x_op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_START,
        C_EXIT,
        C_NOT_EXIT,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic     take_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        x_op_t    x_op;
        logic     upd;
        logic     chk_lo;
        logic     fin;
        cond_t    cond;
        logic     hold;
        upc_t     target;
    } ucode_t;

    // program addresses
    localparam upc_t PC_WAIT  = 4'd0;
    localparam upc_t PC_MULHI = 4'd1;
    localparam upc_t PC_INIT  = 4'd2;
    localparam upc_t PC_MULX0 = 4'd3;
    localparam upc_t PC_TEST  = 4'd4;
    localparam upc_t PC_MULX  = 4'd5;
    localparam upc_t PC_UPD   = 4'd6;
    localparam upc_t PC_MULLO = 4'd7;
    localparam upc_t PC_CHKLO = 4'd8;
    localparam upc_t PC_MULH2 = 4'd9;
    localparam upc_t PC_FINAL = 4'd10;

    localparam ucode_t UC_NOP = '{
        take_in: 1'b0, mul_en: 1'b0, mul_sel: MUL_HI, x_op: X_KEEP,
        upd: 1'b0, chk_lo: 1'b0, fin: 1'b0, cond: C_NEVER, hold: 1'b0,
        target: PC_WAIT
    };

    function automatic ucode_t ucode_rom(input upc_t pc);
        ucode_t w;
        w = UC_NOP;
        case (pc)
            PC_WAIT: begin
                w.take_in = 1'b1;
                w.cond    = C_START;
                w.hold    = 1'b1;
                w.target  = PC_MULHI;
            end
            PC_MULHI: begin
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_HI;
            end
            PC_INIT: begin
                w.x_op = X_INIT;
            end
            PC_MULX0: begin
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_X;
            end
            PC_TEST: begin
                w.x_op   = X_STEP;
                w.cond   = C_EXIT;
                w.target = PC_MULLO;
            end
            PC_MULX: begin
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_X;
            end
            PC_UPD: begin
                w.x_op   = X_STEP;
                w.upd    = 1'b1;
                w.cond   = C_NOT_EXIT;
                w.target = PC_MULX;
            end
            PC_MULLO: begin
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_LO;
            end
            PC_CHKLO: begin
                w.chk_lo = 1'b1;
            end
            PC_MULH2: begin
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_HI;
            end
            PC_FINAL: begin
                w.fin    = 1'b1;
                w.cond   = C_OUT_FREE;
                w.hold   = 1'b1;
                w.target = PC_WAIT;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = PC_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

// File: design/bisection_square_root.sv
`timescale 1ns / 1ps
// Processing: one word at a time; s_tready is high only in the wait state,
//   which is re-entered once the result is loaded into the output register.
// steps_taken = 0..MAX_STEPS; each bisection step is one pass through the
//   single 32x32 squaring unit plus one compare/update.
// Reset: synchronous, active low; clears sequencer, output valid and sets
//   tolerance to 6554 (0.1 in Q16.16).
module bisection_square_root #(
    parameter int MAX_STEPS = bsr_pkg::MAX_STEPS_DEF,  // 1..63
    parameter int FRAC_BITS = bsr_pkg::FRAC_BITS_DEF   // 4..24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input word: [31:0] value
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bsr_pkg::VALUE_W-1:0] s_tdata,
    // result word: [32:0] root, [38:33] steps_taken, [39] converged
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bsr_pkg::RES_W-1:0]   m_tdata,
    // config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import bsr_pkg::*;

    localparam int TGT_W = VALUE_W + FRAC_BITS;   // value at 2F fraction bits
    localparam int SQ_W  = 2 * VALUE_W;
    localparam logic [VALUE_W-1:0] ONE = {{(VALUE_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    // sequencer
    upc_t   pc_reg, pc_next;
    ucode_t uw;

    // datapath registers
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] lo_reg, hi_reg, x_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [STEPS_W-1:0] steps_reg;
    logic               done_reg;
    logic               lo_exact_reg;
    logic [31:0]        tol_reg;

    // output register
    logic               m_tvalid_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [STEPS_W-1:0] steps_out_reg;
    logic               conv_reg;

    // combinational datapath
    logic [VALUE_W-1:0] mul_a;
    logic [SQ_W-1:0]    prod;
    logic [SQ_W-1:0]    tgt64, tol64, diff;
    logic               sq_eq, sq_lt, in_tol, step_exit;
    logic [VALUE_W-1:0] lo_new, hi_new;
    logic [VALUE_W-1:0] mid_keep, mid_lo_up, mid_hi_dn, mid_new;
    logic [VALUE_W-1:0] x_init;
    logic               out_free, accept, cfg_wr, taken;

    function automatic logic [VALUE_W-1:0] midpoint(input logic [VALUE_W-1:0] a,
                                                    input logic [VALUE_W-1:0] b);
        logic [VALUE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VALUE_W:1];
    endfunction

    assign uw       = ucode_rom(pc_reg);
    assign s_tready = uw.take_in;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign tgt64 = {{(SQ_W-TGT_W){1'b0}}, value_reg, {FRAC_BITS{1'b0}}};
    assign tol64 = {{(SQ_W-TGT_W){1'b0}}, tol_reg, {FRAC_BITS{1'b0}}};

    always_comb begin
        case (uw.mul_sel)
            MUL_HI:  mul_a = hi_reg;
            MUL_X:   mul_a = x_reg;
            MUL_LO:  mul_a = lo_reg;
            default: mul_a = x_reg;
        endcase
    end

    assign prod = mul_a * mul_a;

    // compare of the registered square against the target
    assign sq_eq     = (sq_reg == tgt64);
    assign sq_lt     = (sq_reg < tgt64);
    assign diff      = sq_lt ? (tgt64 - sq_reg) : (sq_reg - tgt64);
    assign in_tol    = (diff <= tol64);
    assign step_exit = in_tol || (steps_reg == STEPS_W'(MAX_STEPS));

    // next midpoint for either outcome, picked after the compare
    assign lo_new    = (uw.upd && sq_lt)  ? x_reg : lo_reg;
    assign hi_new    = (uw.upd && !sq_lt) ? x_reg : hi_reg;
    assign mid_keep  = midpoint(lo_reg, hi_reg);
    assign mid_lo_up = midpoint(x_reg, hi_reg);
    assign mid_hi_dn = midpoint(lo_reg, x_reg);
    assign mid_new   = !uw.upd ? mid_keep : (sq_lt ? mid_lo_up : mid_hi_dn);

    // start estimate: zero, exactly one, or first midpoint (sq holds hi*hi)
    assign x_init = (value_reg == '0) ? '0 : (sq_eq ? ONE : mid_keep);

    always_comb begin
        case (uw.cond)
            C_NEVER:    taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_START:    taken = s_tvalid;
            C_EXIT:     taken = step_exit;
            C_NOT_EXIT: taken = !step_exit;
            C_OUT_FREE: taken = out_free;
            default:    taken = 1'b0;
        endcase
        if (taken) begin
            pc_next = uw.target;
        end else if (uw.hold) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + upc_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= PC_WAIT;
            m_tvalid_reg <= 1'b0;
            tol_reg      <= TOL_RESET;
        end else begin
            pc_reg <= pc_next;

            if (cfg_wr && paddr[2] == REG_TOL) begin
                tol_reg <= pwdata;
            end

            if (accept) begin
                value_reg <= s_tdata;
                lo_reg    <= '0;
                hi_reg    <= (s_tdata > ONE) ? s_tdata : ONE;
                steps_reg <= '0;
            end

            if (uw.mul_en) begin
                sq_reg <= prod;
            end

            case (uw.x_op)
                X_INIT: begin
                    x_reg <= x_init;
                end
                X_STEP: begin
                    lo_reg   <= lo_new;
                    hi_reg   <= hi_new;
                    done_reg <= in_tol;
                    if (!step_exit) begin
                        x_reg     <= mid_new;
                        steps_reg <= steps_reg + STEPS_W'(1);
                    end
                end
                default: begin
                end
            endcase

            if (uw.chk_lo) begin
                lo_exact_reg <= sq_eq;
            end

            // final pick: exact lower bound, exact upper bound, else last midpoint
            if (uw.fin && out_free) begin
                m_tvalid_reg  <= 1'b1;
                steps_out_reg <= steps_reg;
                if (lo_exact_reg) begin
                    root_reg <= {1'b0, lo_reg};
                    conv_reg <= 1'b1;
                end else if (sq_eq) begin
                    root_reg <= {1'b0, hi_reg};
                    conv_reg <= 1'b1;
                end else begin
                    root_reg <= {1'b0, x_reg};
                    conv_reg <= done_reg;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {conv_reg, steps_out_reg, root_reg};

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOL) ? tol_reg : 32'd0;

endmodule

// File: design/bsr_checker.sv
`timescale 1ns / 1ps
module bsr_checker #(
    parameter int MAX_STEPS = bsr_pkg::MAX_STEPS_DEF
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bsr_pkg::RES_W-1:0]   m_tdata
);
    import bsr_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in flight: input closes right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    a_steps_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[38:33] <= STEPS_W'(MAX_STEPS))
        else $error("step count above cap");

    // no convergence only when the cap was hit
    a_fail_at_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[39] |-> m_tdata[38:33] == STEPS_W'(MAX_STEPS))
        else $error("non-converged result below cap");

endmodule

bind bisection_square_root bsr_checker #(.MAX_STEPS(MAX_STEPS)) u_bsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/root_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the config port, predicts every result word of
// the bisection square root and compares it field by field.
module root_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [bsr_pkg::VALUE_W-1:0] s_tdata,   // [31:0] value
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [bsr_pkg::RES_W-1:0]   m_tdata,   // [32:0] root, [38:33] steps, [39] converged
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    output int                          errors,
    output int                          pending,
    output int                          checked,
    output int                          capped
);
    import bsr_pkg::*;

    typedef struct packed {
        logic                converged;
        logic [STEPS_W-1:0]  steps;
        logic [ROOT_W-1:0]   root;
    } root_result_t;

    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS_DEF;

    logic [31:0]  tol_reg;
    root_result_t expected_roots[$];
    root_result_t want;
    root_result_t got;

    function automatic logic [63:0] sq_error(input logic [63:0] sq, input logic [63:0] tgt);
        return (sq > tgt) ? sq - tgt : tgt - sq;
    endfunction

    // truncating bisection, squares compared at 2*FRAC_BITS fraction bits
    function automatic root_result_t bisect_root(input logic [31:0] value,
                                                 input logic [31:0] tol);
        logic [63:0]  tgt;
        logic [63:0]  tol_sq;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        int unsigned  n;
        logic         hit;
        root_result_t r;
        tgt    = {32'd0, value} << FRAC_BITS_DEF;
        tol_sq = {32'd0, tol} << FRAC_BITS_DEF;
        lo     = '0;
        hi     = ({32'd0, value} > ONE) ? {32'd0, value} : ONE;
        if (tgt == 0)
            mid = '0;
        else if (hi * hi == tgt)
            mid = ONE;
        else
            mid = (lo + hi) >> 1;
        hit = sq_error(mid * mid, tgt) <= tol_sq;
        n   = 0;
        while (!hit && n < MAX_STEPS_DEF) begin
            mid = (lo + hi) >> 1;
            n++;
            if (mid * mid < tgt)
                lo = mid;
            else
                hi = mid;
            hit = sq_error(mid * mid, tgt) <= tol_sq;
        end
        r.root = mid[ROOT_W-1:0];
        if (lo * lo == tgt) begin
            r.root = lo[ROOT_W-1:0];
            hit    = 1'b1;
        end else if (hi * hi == tgt) begin
            r.root = hi[ROOT_W-1:0];
            hit    = 1'b1;
        end
        r.steps     = n[STEPS_W-1:0];
        r.converged = hit;
        return r;
    endfunction

    initial begin
        errors  = 0;
        pending = 0;
        checked = 0;
        capped  = 0;
        tol_reg = TOL_RESET;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg = TOL_RESET;
            expected_roots.delete();
        end else begin
            // only index 0 exists; writes elsewhere are dropped
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1] == REG_TOL)
                tol_reg = pwdata;
            if (s_tvalid && s_tready)
                expected_roots.push_back(bisect_root(s_tdata, tol_reg));
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(root_result_t)-1:0];
                if (expected_roots.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_roots.pop_front();
                    checked++;
                    if (!want.converged)
                        capped++;
                    if (got.root !== want.root) begin
                        $error("root: expected %0d, got %0d", want.root, got.root);
                        errors++;
                    end
                    if (got.steps !== want.steps) begin
                        $error("steps_taken: expected %0d, got %0d", want.steps, got.steps);
                        errors++;
                    end
                    if (got.converged !== want.converged) begin
                        $error("converged: expected %0d, got %0d",
                               want.converged, got.converged);
                        errors++;
                    end
                end
            end
            pending = expected_roots.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import bsr_pkg::*;

    // tolerance is the only register; paddr[2] carries its index
    localparam logic [PADDR_W-1:0] TOL_ADDR    = {REG_TOL, 2'b00};
    localparam logic [PADDR_W-1:0] UNUSED_ADDR = {~REG_TOL, 2'b00};
    localparam int TAIL_CYCLES   = 16;    // block is back in its wait state well before this
    localparam int HOLD_CYCLES   = 600;   // long receiver hold-off
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_WORDS   = 134;   // ~800 random words over all phases

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata  = '0;   // [31:0] value
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [RES_W-1:0]    m_tdata;         // [32:0] root, [38:33] steps, [39] converged
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    logic quiet    = 1'b0;   // no idling on either side
    logic stall_go = 1'b0;   // asks the receiver for its one long hold-off

    int errors;
    int pending;
    int checked;
    int capped;
    int sent = 0;
    int settings = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    bisection_square_root DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    root_checker checker_i (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked),
        .capped   (capped)
    );

    // Register write: setup cycle, then access cycle until pready.
    // Called right after a rising edge.
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one word; returns at the edge where it was taken.
    // A gap lowers tvalid first, otherwise tvalid stays high back to back.
    task automatic send_value(input logic [31:0] v);
        if (!quiet && $urandom_range(0, 99) < 35) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // Stop offering, wait out every expected word, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic set_tolerance(input logic [31:0] tol);
        apb_write(TOL_ADDR, tol);
        settings++;
    endtask

    // Receiver: random back-pressure, one long hold-off on request while
    // the sender keeps offering, so the block fills up and drops s_tready.
    initial begin : receiver
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_go && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 35);
        end
    end

    // Hard stop: the slowest correct run ends well before this timeout.
    initial begin : watchdog
        #20_000_000;
        $display("bisection_square_root test failed");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] v;
        logic [31:0] tol;
        int unsigned m;
        logic [31:0] directed_reset[] = '{
            32'h0000_0000,      // zero radicand, estimate starts at 0
            32'h0001_0000,      // exactly 1.0
            32'h0000_0001,      // smallest nonzero
            32'h0000_FFFF,      // just under 1.0
            32'h0001_0001,      // just over 1.0
            32'h0000_0004,      // exact root (2/256)
            32'h0004_0000,      // 4.0, exact root 2.0
            32'h0001_8000,      // 1.5
            32'h0000_0100,
            32'h0000_0002,
            32'hFFFE_0001,      // largest exact square
            32'hFFFF_FFFF,      // top of range
            32'h8000_0000,
            32'h7FFF_FFFF,
            32'h5555_5555,
            32'hAAAA_AAAA,
            32'h00BC_614E
        };
        logic [31:0] directed_zero[] = '{
            32'h0000_0002,      // no exact root, midpoint stalls -> cap
            32'h0002_0000,      // 2.0, runs to the cap
            32'h0001_0000,
            32'hFFFE_0001,
            32'h0000_0000
        };
        logic [31:0] directed_wide[] = '{
            32'h0000_0000,
            32'hFFFF_FFFF,      // huge tolerance, top of range
            32'h0000_0007
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed, reset tolerance (0.1) ---
        foreach (directed_reset[i]) send_value(directed_reset[i]);
        drain();

        // write to a register index that does not exist; must be ignored
        apb_write(UNUSED_ADDR, 32'h0000_0000);
        foreach (directed_reset[i]) if (i < 4) send_value(directed_reset[i]);
        drain();

        // --- directed, zero tolerance: exact or stalled at the cap ---
        set_tolerance(32'h0000_0000);
        foreach (directed_zero[i]) send_value(directed_zero[i]);
        drain();

        // --- directed, full-scale tolerance ---
        set_tolerance(32'hFFFF_FFFF);
        foreach (directed_wide[i]) send_value(directed_wide[i]);
        drain();

        // --- random phases, one tolerance setting each ---
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: tol = 32'h0000_0000;
                1: tol = 32'hFFFF_FFFF;
                2: tol = 32'h0000_0001;
                3: tol = $urandom_range(0, 65535);
                4: tol = TOL_RESET;
                default: tol = $urandom;
            endcase
            quiet <= (p == 3);        // one phase runs flat out on both sides
            set_tolerance(tol);
            if (p == 4)
                stall_go <= 1'b1;     // long hold-off lands inside this phase
            for (int k = 0; k < PHASE_WORDS; k++) begin
                case ($urandom_range(0, 7))
                    0: begin                          // exact square root exists
                        m = $urandom_range(0, 65535);
                        v = m * m;
                    end
                    1: v = $urandom_range(0, 65536);  // at or below 1.0
                    2: v = 32'h0001_0000 ^ $urandom_range(0, 31);
                    3: v = $urandom >> $urandom_range(0, 31);
                    4: v = 32'hFFFF_FFFF - $urandom_range(0, 255);
                    default: v = $urandom;
                endcase
                send_value(v);
            end
            drain();
        end

        $display("sent %0d values under %0d tolerance settings plus the reset value",
                 sent, settings);
        $display("checked %0d results, %0d of them stopped at the step cap",
                 checked, capped);
        if (errors == 0)
            $display("bisection_square_root test passed");
        else
            $display("bisection_square_root test failed");
        $finish;
    end

endmodule

// File: sim.f
design/bsr_pkg.sv
design/bisection_square_root.sv
design/bsr_checker.sv
tb/sv/root_checker.sv
tb/sv/tb.sv
